@@ rtl/framed_message_receiver_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef FRAMED_MESSAGE_RECEIVER_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FMR_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("fmr assertion failed");

// Next-cycle implication, disabled during reset.
`define FMR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("fmr assertion failed");

`endif

@@ rtl/fmr_pkg.sv @@
package fmr_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_NOSYNC   = 2'd0,
        ST_NOTREADY = 2'd1,
        ST_GOOD     = 2'd2,
        ST_BADSUM   = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic CFG_SYNC_BYTE    = 1'b0;
    localparam logic CFG_LENGTH_LIMIT = 1'b1;

    localparam logic [7:0] SYNC_BYTE_RESET    = 8'd170;
    localparam logic [7:0] LENGTH_LIMIT_RESET = 8'd255;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] running_sum;
        logic [7:0] bytes_seen;
        logic [7:0] payload_length;
        logic [7:0] opcode_held;
    } parse_state_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] frame_opcode;
        logic [7:0] frame_length;
        logic       payload_valid;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
    } result_t;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] length_limit;
    } cfg_t;

endpackage

@@ rtl/fmr_parser.sv @@
module fmr_parser (
    input  fmr_pkg::parse_state_t cur,
    input  fmr_pkg::cfg_t         cfg,
    input  logic [7:0]            rx_byte,
    output fmr_pkg::parse_state_t nxt,
    output fmr_pkg::result_t      res
);

    logic [7:0] sum_plus;
    logic [7:0] seen_plus;

    assign sum_plus  = cur.running_sum + rx_byte;
    assign seen_plus = cur.bytes_seen + 8'd1;

    always_comb begin
        nxt               = cur;
        res.status        = fmr_pkg::ST_NOTREADY;
        res.payload_valid = 1'b0;
        res.payload_index = 8'd0;
        res.payload_byte  = 8'd0;

        unique case (cur.phase)
            fmr_pkg::PH_OPCODE: begin
                nxt.opcode_held    = rx_byte;
                nxt.payload_length = 8'd0;
                nxt.running_sum    = sum_plus;
                nxt.phase          = fmr_pkg::PH_LENGTH;
            end
            fmr_pkg::PH_LENGTH: begin
                if (rx_byte < cfg.length_limit) begin
                    nxt.bytes_seen     = 8'd0;
                    nxt.payload_length = rx_byte;
                    nxt.running_sum    = sum_plus;
                    nxt.phase = (rx_byte == 8'd0) ? fmr_pkg::PH_CHECK : fmr_pkg::PH_PAYLOAD;
                end else begin
                    // a length at or above the limit drops the frame
                    nxt.phase = fmr_pkg::PH_HUNT;
                end
            end
            fmr_pkg::PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_index = cur.bytes_seen;
                res.payload_byte  = rx_byte;
                nxt.running_sum   = sum_plus;
                nxt.bytes_seen    = seen_plus;
                if (seen_plus == cur.payload_length) begin
                    nxt.phase = fmr_pkg::PH_CHECK;
                end
            end
            fmr_pkg::PH_CHECK: begin
                nxt.running_sum = sum_plus;
                nxt.phase       = fmr_pkg::PH_HUNT;
                res.status = (sum_plus == 8'd0) ? fmr_pkg::ST_GOOD : fmr_pkg::ST_BADSUM;
            end
            default: begin
                nxt.phase = fmr_pkg::PH_HUNT;
                if (rx_byte == cfg.sync_byte) begin
                    nxt.running_sum = rx_byte;
                    nxt.phase       = fmr_pkg::PH_OPCODE;
                end else begin
                    res.status = fmr_pkg::ST_NOSYNC;
                end
            end
        endcase

        res.frame_opcode = nxt.opcode_held;
        res.frame_length = nxt.payload_length;
    end

endmodule

@@ rtl/framed_message_receiver_top.sv @@
// Frame receiver: takes one byte per transfer and returns one status result per byte,
// parsing sync, opcode, length, payload and checksum fields on the fly. Throughput is
// one byte per clock while the skid stage is empty; a byte's result passes through the
// single parse step (one 8-bit add and compare) into the output register, or into the
// skid stage while the output stalls. A one-entry skid stage behind the output
// register lets a byte be taken while a result is still waiting; input ready drops
// only while the skid stage is occupied. Payload bytes are passed out with their index
// and are not buffered. Configuration writes take effect at the next clock.
module framed_message_receiver_top (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_frame_opcode,
    output logic [7:0] m_frame_length,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_index,
    output logic [7:0] m_payload_byte
);

    fmr_pkg::cfg_t         cfg_reg;
    fmr_pkg::parse_state_t state_reg;
    fmr_pkg::parse_state_t state_next;
    fmr_pkg::result_t      step_res;
    fmr_pkg::result_t      out_reg;
    fmr_pkg::result_t      skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  accept;
    logic                  out_free;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte    <= fmr_pkg::SYNC_BYTE_RESET;
            cfg_reg.length_limit <= fmr_pkg::LENGTH_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fmr_pkg::CFG_SYNC_BYTE:    cfg_reg.sync_byte    <= cfg_wdata;
                fmr_pkg::CFG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fmr_parser u_parser (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .rx_byte (s_rx_byte),
        .nxt     (state_next),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= fmr_pkg::PH_HUNT;
            state_reg.running_sum    <= 8'd0;
            state_reg.bytes_seen     <= 8'd0;
            state_reg.payload_length <= 8'd0;
            state_reg.opcode_held    <= 8'd0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // output register with skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        if (!out_free && accept) begin
            skid_reg <= step_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_frame_opcode  = out_reg.frame_opcode;
    assign m_frame_length  = out_reg.frame_length;
    assign m_payload_valid = out_reg.payload_valid;
    assign m_payload_index = out_reg.payload_index;
    assign m_payload_byte  = out_reg.payload_byte;

endmodule

@@ rtl/fmr_checker.sv @@
`include "framed_message_receiver_top_assert.svh"

module fmr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_wr_en,
    input logic       cfg_index,
    input logic [7:0] cfg_wdata,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [7:0] m_frame_opcode,
    input logic [7:0] m_frame_length,
    input logic       m_payload_valid,
    input logic [7:0] m_payload_index,
    input logic [7:0] m_payload_byte
);

    logic [7:0] cfg_seen;
    logic       s_seen;

    // ports observed but not otherwise checked
    assign cfg_seen = cfg_wdata ^ {7'd0, cfg_index ^ cfg_wr_en};
    assign s_seen   = s_valid ^ s_ready ^ (^s_rx_byte) ^ (^cfg_seen);

    // a stalled result holds
    `FMR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_payload_byte) && $stable(m_payload_index) && $stable(m_frame_opcode) && $stable(m_frame_length) && $stable(m_payload_valid))

    // non-payload results carry zero index and byte
    `FMR_ASSERT_IMPLY(a_idle_payload, m_valid && !m_payload_valid, m_payload_index == 8'd0 && m_payload_byte == 8'd0)

    // a payload byte is never a frame verdict
    `FMR_ASSERT_IMPLY(a_payload_status, m_valid && m_payload_valid, m_status == fmr_pkg::ST_NOTREADY)

    // payload index stays within the announced length
    `FMR_ASSERT_IMPLY(a_payload_index, m_valid && m_payload_valid && (s_seen || !s_seen), m_payload_index < m_frame_length)

endmodule

bind framed_message_receiver_top fmr_checker u_fmr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_rx_byte       (s_rx_byte),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_frame_opcode  (m_frame_opcode),
    .m_frame_length  (m_frame_length),
    .m_payload_valid (m_payload_valid),
    .m_payload_index (m_payload_index),
    .m_payload_byte  (m_payload_byte)
);
